FILE: rtl/core/prr_pkg.sv
package prr_pkg;

  localparam int unsigned WordWidth    = 64;
  localparam int unsigned ShardWidth   = 16;
  localparam int unsigned KindOutWidth = 8;
  localparam int unsigned PayOutWidth  = 56;
  localparam int unsigned CountWidth   = 32;
  localparam int unsigned NumCounters  = 6;
  localparam int unsigned StepBits     = $clog2(WordWidth);

  localparam int unsigned InDataWidth  = 80;
  localparam int unsigned OutDataWidth = 280;

  localparam logic [ShardWidth-1:0] NoShard       = 16'hFFFF;
  localparam logic [ShardWidth-1:0] KindPool      = 16'd0;
  localparam logic [ShardWidth-1:0] KindDistrib   = 16'd1;
  localparam logic [ShardWidth-1:0] KindShard     = 16'd2;

  typedef enum logic {
    OP_RESOLVE = 1'b0,
    OP_CLEAR   = 1'b1
  } prr_op_e;

  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_INVALID_ARG   = 2'd1,
    ST_INVALID_SHARD = 2'd2,
    ST_UNSUPPORTED   = 2'd3
  } prr_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIVIDE,
    S_RESULT
  } prr_state_e;

  // statistics counter update request
  typedef struct packed {
    logic clear;
    logic attempts;
    logic exact;
    logic distributed;
    logic non_caller;
    logic bad_shard;
    logic unsupported;
  } prr_stat_upd_t;

  typedef struct packed {
    logic [CountWidth-1:0] unsupported;
    logic [CountWidth-1:0] bad_shard;
    logic [CountWidth-1:0] non_caller;
    logic [CountWidth-1:0] distributed;
    logic [CountWidth-1:0] exact;
    logic [CountWidth-1:0] attempts;
  } prr_counts_t;

endpackage

FILE: rtl/core/placement_resolver_round_robin_unit.sv
// placement resolver with round-robin shard selection
//
// input stream: one word per request. tuser carries the opcode (resolve or
// clear); tdata carries the placement word and the caller shard.
// output stream: one word per request with status, chosen shard, decoded
// kind and payload, and the six statistics counters after the request.
// config: cfg_we_i writes the 16 bit shard count; write only while idle.
//
// a request is taken only while the unit is idle. a distributed request with a
// caller below the shard count runs the ticket modulo shard count through a
// bit-serial divider, one quotient bit per cycle, then moves on to the result
// state. every other request goes from accept straight to the result state.
// in the result state the output word is registered, and the next request is
// taken once the unit has returned to idle.
// the result sits in an output register; when the receiver stalls the
// unit holds it and finishes the next request only once the slot is free.
// reset: shard count 1, ticket and counters zero, output empty.
module placement_resolver_round_robin_unit
  import prr_pkg::*;
#(
  parameter int unsigned KIND_BITS     = 8,
  parameter int unsigned COUNTER_WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [ShardWidth-1:0]   cfg_wdata_i,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // placement_word[63:0], caller_shard[79:64]
  input  logic [InDataWidth-1:0]  s_axis_tdata,
  // opcode
  input  logic                    s_axis_tuser,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // status[1:0], chosen_shard[17:2], kind_out[25:18], payload_out[81:26],
  // attempts_count[113:82], exact_count[145:114], distributed_count[177:146],
  // non_caller_count[209:178], bad_shard_count[241:210],
  // unsupported_count[273:242], zero pad up to 279
  output logic [OutDataWidth-1:0] m_axis_tdata
);

  localparam int unsigned PayWidth = WordWidth - KIND_BITS;

  prr_state_e state_q, state_d;

  logic [ShardWidth-1:0] shard_count_q;
  logic [WordWidth-1:0]  ticket_q;
  prr_op_e               op_q;
  logic [WordWidth-1:0]  word_q;
  logic [ShardWidth-1:0] caller_q;

  logic                  s_accept;
  logic                  need_div;
  logic                  commit;
  logic                  div_busy;
  logic [ShardWidth-1:0] div_rem;

  logic [WordWidth-1:0]  in_word;
  logic [ShardWidth-1:0] in_caller;
  logic [KIND_BITS-1:0]  in_kind;

  logic [KIND_BITS-1:0]  kind;
  logic [PayWidth-1:0]   payload;
  logic [63:0]           kind_ext;
  logic [63:0]           pay_ext;
  logic [ShardWidth:0]   caller_inc;
  logic [ShardWidth-1:0] sel;

  prr_status_e           res_status;
  logic [ShardWidth-1:0] res_chosen;
  logic [KindOutWidth-1:0] res_kind;
  logic [PayOutWidth-1:0]  res_payload;
  logic                  ticket_inc;
  prr_stat_upd_t         upd;
  prr_counts_t           counts;

  logic                    m_valid_q;
  logic [OutDataWidth-1:0] m_data_q;

  assign in_word   = s_axis_tdata[WordWidth-1:0];
  assign in_caller = s_axis_tdata[WordWidth+ShardWidth-1:WordWidth];
  assign in_kind   = in_word[KIND_BITS-1:0];

  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign need_div = (prr_op_e'(s_axis_tuser) == OP_RESOLVE) && (shard_count_q != '0) &&
                    (ShardWidth'(in_kind) == KindDistrib) &&
                    (in_kind[KIND_BITS-1:ShardWidth > KIND_BITS ? 0 : 0] == in_kind) &&
                    (in_caller < shard_count_q);

  assign commit = (state_q == S_RESULT) && (!m_valid_q || m_axis_tready);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_accept) begin
          state_d = need_div ? S_DIVIDE : S_RESULT;
        end
      end
      S_DIVIDE: begin
        if (!div_busy) begin
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        if (commit) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    case (state_q)
      S_IDLE:  s_axis_tready = 1'b1;
      default: s_axis_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      shard_count_q <= 16'd1;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        shard_count_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      op_q     <= prr_op_e'(s_axis_tuser);
      word_q   <= in_word;
      caller_q <= in_caller;
    end
  end

  prr_mod_unit u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (s_accept && need_div),
    .dividend_i (ticket_q),
    .divisor_i  (shard_count_q),
    .busy_o     (div_busy),
    .rem_o      (div_rem)
  );

  assign kind       = word_q[KIND_BITS-1:0];
  assign payload    = word_q[WordWidth-1:KIND_BITS];
  assign caller_inc = {1'b0, caller_q} + 17'd1;

  // step past the caller's own shard when more than one is in use
  always_comb begin
    sel = div_rem;
    if ((shard_count_q > 16'd1) && (div_rem == caller_q)) begin
      sel = (caller_inc == {1'b0, shard_count_q}) ? '0 : caller_inc[ShardWidth-1:0];
    end
  end

  // request decision
  always_comb begin
    res_status = ST_OK;
    res_chosen = NoShard;
    ticket_inc = 1'b0;
    upd        = '0;
    kind_ext   = 64'(kind);
    pay_ext    = 64'(payload);
    if (op_q == OP_CLEAR) begin
      upd.clear = 1'b1;
      kind_ext  = '0;
      pay_ext   = '0;
    end else if (shard_count_q == '0) begin
      res_status = ST_INVALID_ARG;
    end else begin
      upd.attempts = 1'b1;
      if (16'(kind) == KindShard && 64'(kind) == kind_ext) begin
        if (payload >= PayWidth'(shard_count_q)) begin
          upd.bad_shard = 1'b1;
          res_status    = ST_INVALID_SHARD;
        end else begin
          upd.exact  = 1'b1;
          res_chosen = payload[ShardWidth-1:0];
        end
      end else if (16'(kind) == KindDistrib) begin
        if (caller_q >= shard_count_q) begin
          res_status = ST_INVALID_ARG;
        end else begin
          ticket_inc      = 1'b1;
          upd.distributed = 1'b1;
          upd.non_caller  = (sel != caller_q);
          res_chosen      = sel;
        end
      end else begin
        upd.unsupported = 1'b1;
        res_status      = ST_UNSUPPORTED;
      end
    end
  end

  assign res_kind    = kind_ext[KindOutWidth-1:0];
  assign res_payload = pay_ext[PayOutWidth-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticket_q <= '0;
    end else if (commit) begin
      if (upd.clear) begin
        ticket_q <= '0;
      end else if (ticket_inc) begin
        ticket_q <= ticket_q + 64'd1;
      end
    end
  end

  prr_stats #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_stats (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .commit_i (commit && !(upd == '0)),
    .upd_i    (upd),
    .next_o   (counts)
  );

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (commit) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      m_data_q <= {6'd0, counts.unsupported, counts.bad_shard, counts.non_caller,
                   counts.distributed, counts.exact, counts.attempts,
                   res_payload, res_kind, res_chosen, res_status};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

FILE: rtl/core/prr_mod_unit.sv
module prr_mod_unit
  import prr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [WordWidth-1:0]  dividend_i,
  input  logic [ShardWidth-1:0] divisor_i,
  output logic                  busy_o,
  output logic [ShardWidth-1:0] rem_o
);

  logic                  busy_q, busy_d;
  logic [StepBits-1:0]   step_q, step_d;
  logic [WordWidth-1:0]  quo_q, quo_d;
  logic [ShardWidth-1:0] rem_q, rem_d;
  logic [ShardWidth:0]   trial;
  logic                  fits;

  // one restoring step per cycle, msb first
  assign trial = {rem_q, quo_q[WordWidth-1]};
  assign fits  = (trial >= {1'b0, divisor_i});

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      quo_d  = {quo_q[WordWidth-2:0], 1'b0};
      rem_d  = fits ? ShardWidth'(trial - {1'b0, divisor_i}) : trial[ShardWidth-1:0];
      step_d = step_q + StepBits'(1);
      if (step_q == '1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

FILE: rtl/core/prr_stats.sv
module prr_stats
  import prr_pkg::*;
#(
  parameter int unsigned COUNTER_WIDTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          commit_i,
  input  prr_stat_upd_t upd_i,
  output prr_counts_t   next_o
);

  logic [COUNTER_WIDTH-1:0] ctr_q [NumCounters];
  logic [COUNTER_WIDTH-1:0] ctr_d [NumCounters];
  logic [NumCounters-1:0]   bump;
  logic [63:0]              ext  [NumCounters];

  assign bump = {upd_i.unsupported, upd_i.bad_shard, upd_i.non_caller,
                 upd_i.distributed, upd_i.exact, upd_i.attempts};

  // clear to zero, or saturating increment at all ones
  always_comb begin
    for (int i = 0; i < NumCounters; i++) begin
      ctr_d[i] = ctr_q[i];
      if (upd_i.clear) begin
        ctr_d[i] = '0;
      end else if (bump[i] && (ctr_q[i] != '1)) begin
        ctr_d[i] = ctr_q[i] + COUNTER_WIDTH'(1);
      end
      ext[i] = 64'(ctr_d[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCounters; i++) begin
        ctr_q[i] <= '0;
      end
    end else if (commit_i) begin
      for (int i = 0; i < NumCounters; i++) begin
        ctr_q[i] <= ctr_d[i];
      end
    end
  end

  assign next_o.attempts    = ext[0][CountWidth-1:0];
  assign next_o.exact       = ext[1][CountWidth-1:0];
  assign next_o.distributed = ext[2][CountWidth-1:0];
  assign next_o.non_caller  = ext[3][CountWidth-1:0];
  assign next_o.bad_shard   = ext[4][CountWidth-1:0];
  assign next_o.unsupported = ext[5][CountWidth-1:0];

endmodule

FILE: rtl/core/prr_checker.sv
module prr_checker
  import prr_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    s_axis_tvalid,
  input logic                    s_axis_tready,
  input logic                    m_axis_tvalid,
  input logic                    m_axis_tready,
  input logic [OutDataWidth-1:0] m_axis_tdata
);

  logic [1:0]            out_status;
  logic [ShardWidth-1:0] out_chosen;

  assign out_status = m_axis_tdata[1:0];
  assign out_chosen = m_axis_tdata[17:2];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a request is in progress");

  a_no_shard_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (out_status != ST_OK) |-> out_chosen == NoShard)
    else $error("failed request carries a shard number");

  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("output word without a request in progress");

endmodule

bind placement_resolver_round_robin_unit prr_checker u_prr_checker (.*);

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import prr_pkg::*;

  localparam int unsigned KindBits    = 8;
  localparam int unsigned PadWidth    = OutDataWidth - 2 - ShardWidth - KindOutWidth
                                        - PayOutWidth - NumCounters * CountWidth;
  localparam int unsigned IdleLimit   = 5000;
  localparam int unsigned DrainCycles = 100;
  localparam int unsigned HoldOff     = 500;
  localparam int unsigned PhaseItems  = 150;
  localparam int unsigned NumPhases   = 8;
  localparam int unsigned MaxPrinted  = 40;

  localparam logic [KindBits-1:0] KindPoolCode    = KindPool[KindBits-1:0];
  localparam logic [KindBits-1:0] KindDistribCode = KindDistrib[KindBits-1:0];
  localparam logic [KindBits-1:0] KindShardCode   = KindShard[KindBits-1:0];

  // same layout as m_axis_tdata
  typedef struct packed {
    logic [PadWidth-1:0]     pad;
    prr_counts_t             counts;
    logic [PayOutWidth-1:0]  payload;
    logic [KindOutWidth-1:0] kind;
    logic [ShardWidth-1:0]   chosen;
    prr_status_e             status;
  } placement_result_t;

  typedef struct {
    logic                  is_cfg;
    logic [ShardWidth-1:0] cfg_val;
    prr_op_e               op;
    logic [WordWidth-1:0]  word;
    logic [ShardWidth-1:0] caller;
    logic                  typed;
    prr_status_e           want_status;
    logic [ShardWidth-1:0] want_shard;
  } stim_row_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [ShardWidth-1:0]   cfg_wdata_i = '0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [InDataWidth-1:0]  s_axis_tdata = '0;
  logic                    s_axis_tuser = 1'b0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OutDataWidth-1:0] m_axis_tdata;

  // shadow state of the resolver
  logic [ShardWidth-1:0] shard_cnt = 16'd1;
  logic [WordWidth-1:0]  ticket = '0;
  prr_counts_t           stats = '0;

  placement_result_t pending_results[$];
  stim_row_t         directed_rows[$];

  string count_names[NumCounters] = '{"attempts_count", "exact_count", "distributed_count",
                                      "non_caller_count", "bad_shard_count",
                                      "unsupported_count"};
  logic [ShardWidth-1:0] phase_counts[NumPhases] = '{16'd3, 16'd1, 16'd65535, 16'd2,
                                                     16'd0, 16'd7, 16'd0, 16'd5};

  int unsigned error_count = 0;
  int unsigned results_checked = 0;
  int unsigned n_exact = 0;
  int unsigned n_distrib = 0;
  int unsigned n_clear = 0;
  int unsigned n_other = 0;
  int unsigned n_cfg = 0;
  int unsigned sender_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_off_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_off_req = 0;
  int unsigned hold_off_seen = 0;

  placement_resolver_round_robin_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  function automatic placement_result_t predict_placement(input prr_op_e op,
      input logic [WordWidth-1:0] word, input logic [ShardWidth-1:0] caller);
    placement_result_t    r;
    logic [KindBits-1:0]  kind;
    logic [WordWidth-1:0] payload;
    logic [WordWidth-1:0] cnt;
    logic [WordWidth-1:0] who;
    logic [WordWidth-1:0] pick;
    kind    = word[KindBits-1:0];
    payload = word >> KindBits;
    cnt     = {48'd0, shard_cnt};
    who     = {48'd0, caller};
    r        = '0;
    r.status = ST_OK;
    r.chosen = NoShard;
    if (op == OP_CLEAR) begin
      ticket  = '0;
      stats   = '0;
      kind    = '0;
      payload = '0;
    end else if (shard_cnt == '0) begin
      r.status = ST_INVALID_ARG;
    end else begin
      stats.attempts = sat_inc(stats.attempts);
      if (kind == KindShardCode) begin
        if (payload >= cnt) begin
          stats.bad_shard = sat_inc(stats.bad_shard);
          r.status = ST_INVALID_SHARD;
        end else begin
          stats.exact = sat_inc(stats.exact);
          r.chosen = payload[ShardWidth-1:0];
        end
      end else if (kind == KindDistribCode) begin
        if (who >= cnt) begin
          r.status = ST_INVALID_ARG;
        end else begin
          pick   = ticket % cnt;
          ticket = ticket + 1'b1;
          // never hand the caller its own shard unless it is the only one
          if (cnt > 1 && pick == who) pick = (who + 1'b1) % cnt;
          stats.distributed = sat_inc(stats.distributed);
          if (pick != who) stats.non_caller = sat_inc(stats.non_caller);
          r.chosen = pick[ShardWidth-1:0];
        end
      end else begin
        stats.unsupported = sat_inc(stats.unsupported);
        r.status = ST_UNSUPPORTED;
      end
    end
    r.kind    = kind[KindOutWidth-1:0];
    r.payload = payload[PayOutWidth-1:0];
    r.counts  = stats;
    return r;
  endfunction

  function automatic void add_item(input prr_op_e op, input logic [WordWidth-1:0] word,
      input logic [ShardWidth-1:0] caller, input logic typed, input prr_status_e st,
      input logic [ShardWidth-1:0] shard);
    stim_row_t row;
    row.is_cfg      = 1'b0;
    row.cfg_val     = '0;
    row.op          = op;
    row.word        = word;
    row.caller      = caller;
    row.typed       = typed;
    row.want_status = st;
    row.want_shard  = shard;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_cfg(input logic [ShardWidth-1:0] v);
    stim_row_t row;
    row.is_cfg      = 1'b1;
    row.cfg_val     = v;
    row.op          = OP_RESOLVE;
    row.word        = '0;
    row.caller      = '0;
    row.typed       = 1'b0;
    row.want_status = ST_OK;
    row.want_shard  = NoShard;
    directed_rows.push_back(row);
  endfunction

  task automatic report_mismatch(input string what, input logic [WordWidth-1:0] got_v,
      input logic [WordWidth-1:0] want_v);
    error_count++;
    if (error_count <= MaxPrinted)
      $display("mismatch at result %0d: %s got 0x%0h want 0x%0h",
               results_checked, what, got_v, want_v);
  endtask

  task automatic check_result(input logic [OutDataWidth-1:0] data);
    placement_result_t                   got;
    placement_result_t                   want;
    logic [NumCounters*CountWidth-1:0]   got_c;
    logic [NumCounters*CountWidth-1:0]   want_c;
    got = data;
    results_checked++;
    if (pending_results.size() == 0) begin
      report_mismatch("word with nothing pending, low tdata", data[WordWidth-1:0], '0);
      return;
    end
    want = pending_results.pop_front();
    if (got.status !== want.status) report_mismatch("status", got.status, want.status);
    if (got.chosen !== want.chosen) report_mismatch("chosen_shard", got.chosen, want.chosen);
    if (got.kind !== want.kind) report_mismatch("kind_out", got.kind, want.kind);
    if (got.payload !== want.payload) report_mismatch("payload_out", got.payload, want.payload);
    if (got.pad !== want.pad) report_mismatch("pad bits", got.pad, want.pad);
    got_c  = got.counts;
    want_c = want.counts;
    for (int i = 0; i < NumCounters; i++) begin
      if (got_c[i*CountWidth +: CountWidth] !== want_c[i*CountWidth +: CountWidth])
        report_mismatch(count_names[i], got_c[i*CountWidth +: CountWidth],
                        want_c[i*CountWidth +: CountWidth]);
    end
  endtask

  task automatic offer_request(input prr_op_e op, input logic [WordWidth-1:0] word,
      input logic [ShardWidth-1:0] caller, input logic typed, input prr_status_e want_status,
      input logic [ShardWidth-1:0] want_shard);
    placement_result_t r;
    while ($urandom_range(99) < sender_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {caller, word};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    r = predict_placement(op, word, caller);
    if (typed) begin
      r.status = want_status;
      r.chosen = want_shard;
    end
    pending_results.push_back(r);
    if (op == OP_CLEAR) n_clear++;
    else if (word[KindBits-1:0] == KindShardCode) n_exact++;
    else if (word[KindBits-1:0] == KindDistribCode) n_distrib++;
    else n_other++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_shard_count(input logic [ShardWidth-1:0] v);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    shard_cnt = v;
    n_cfg++;
  endtask

  // mostly exact and distributed requests, aimed at the range edges
  task automatic random_request();
    prr_op_e                op;
    logic [WordWidth-1:0]   word;
    logic [PayOutWidth-1:0] payload;
    logic [ShardWidth-1:0]  caller;
    int unsigned            pick;
    int unsigned            variant;
    op      = OP_RESOLVE;
    word    = {$urandom, $urandom};
    payload = word[WordWidth-1:KindBits];
    caller  = 16'($urandom);
    pick    = $urandom_range(99);
    variant = $urandom_range(3);
    if (pick < 4) begin
      op = OP_CLEAR;
    end else if (pick < 45) begin
      case (variant)
        0: caller = (shard_cnt == 0) ? '0 : 16'($urandom % shard_cnt);
        1: caller = (shard_cnt == 0) ? '0 : 16'(ticket % shard_cnt);
        2: caller = shard_cnt;
        default: ;
      endcase
      word = {payload, KindDistribCode};
    end else if (pick < 85) begin
      case (variant)
        0: payload = (shard_cnt == 0) ? '0 : 56'($urandom % shard_cnt);
        1: payload = 56'(shard_cnt);
        2: payload = 56'(shard_cnt) - 1'b1;
        default: ;
      endcase
      word = {payload, KindShardCode};
    end else if (pick < 93) begin
      word = {payload, KindPoolCode};
    end
    offer_request(op, word, caller, 1'b0, ST_OK, NoShard);
  endtask

  // output side: check accepted words, drive tready
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
      if (hold_off_req != hold_off_seen) begin
        hold_off_seen = hold_off_req;
        hold_off_left = HoldOff;
      end
      if (hold_off_left != 0) begin
        hold_off_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no word moved for %0d cycles", IdleLimit);
        $display("** placement_resolver_round_robin_unit: FAILED **");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    // shard count 1 after reset
    add_item(OP_RESOLVE, {56'd0, KindShardCode}, 16'd0, 1'b1, ST_OK, 16'd0);
    add_item(OP_RESOLVE, {56'd1, KindShardCode}, 16'd0, 1'b1, ST_INVALID_SHARD, NoShard);
    add_item(OP_RESOLVE, {56'd0, KindDistribCode}, 16'd0, 1'b1, ST_OK, 16'd0);
    add_item(OP_RESOLVE, {56'd9, KindDistribCode}, 16'd0, 1'b1, ST_OK, 16'd0);
    add_item(OP_RESOLVE, {56'd0, KindDistribCode}, 16'd1, 1'b1, ST_INVALID_ARG, NoShard);
    add_item(OP_RESOLVE, {56'd0, KindPoolCode}, 16'd0, 1'b1, ST_UNSUPPORTED, NoShard);
    add_item(OP_RESOLVE, '1, 16'hFFFF, 1'b1, ST_UNSUPPORTED, NoShard);
    add_item(OP_RESOLVE, {56'hFF_FFFF_FFFF_FFFF, KindShardCode}, 16'd0, 1'b1,
             ST_INVALID_SHARD, NoShard);
    add_item(OP_CLEAR, '1, 16'hFFFF, 1'b1, ST_OK, NoShard);
    // no shards configured
    add_cfg(16'd0);
    add_item(OP_RESOLVE, {56'd0, KindShardCode}, 16'd0, 1'b1, ST_INVALID_ARG, NoShard);
    add_item(OP_RESOLVE, {56'd0, KindDistribCode}, 16'd0, 1'b1, ST_INVALID_ARG, NoShard);
    add_item(OP_RESOLVE, {56'd0, KindPoolCode}, 16'd0, 1'b1, ST_INVALID_ARG, NoShard);
    add_item(OP_CLEAR, '0, 16'd0, 1'b1, ST_OK, NoShard);
    // largest shard count
    add_cfg(16'hFFFF);
    add_item(OP_RESOLVE, {56'd65534, KindShardCode}, 16'd0, 1'b1, ST_OK, 16'd65534);
    add_item(OP_RESOLVE, {56'd65535, KindShardCode}, 16'd0, 1'b1, ST_INVALID_SHARD, NoShard);
    add_item(OP_RESOLVE, {56'd0, KindDistribCode}, 16'hFFFF, 1'b1, ST_INVALID_ARG, NoShard);
    add_item(OP_RESOLVE, {56'd0, KindDistribCode}, 16'd0, 1'b0, ST_OK, NoShard);
    add_item(OP_RESOLVE, {56'd0, KindDistribCode}, 16'd1, 1'b0, ST_OK, NoShard);
    add_item(OP_RESOLVE, {56'd5, 8'd3}, 16'd0, 1'b1, ST_UNSUPPORTED, NoShard);
    // two shards, ticket collides with the caller
    add_cfg(16'd2);
    add_item(OP_RESOLVE, {56'd0, KindDistribCode}, 16'd0, 1'b0, ST_OK, NoShard);
    add_item(OP_RESOLVE, {56'd0, KindDistribCode}, 16'd1, 1'b0, ST_OK, NoShard);
    add_item(OP_RESOLVE, {56'd0, KindDistribCode}, 16'd0, 1'b0, ST_OK, NoShard);
    add_item(OP_CLEAR, {$urandom, $urandom}, 16'($urandom), 1'b0, ST_OK, NoShard);
    add_item(OP_RESOLVE, {56'd0, KindDistribCode}, 16'd1, 1'b0, ST_OK, NoShard);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        write_shard_count(directed_rows[i].cfg_val);
      end else begin
        offer_request(directed_rows[i].op, directed_rows[i].word, directed_rows[i].caller,
                      directed_rows[i].typed, directed_rows[i].want_status,
                      directed_rows[i].want_shard);
      end
    end

    for (int p = 0; p < NumPhases; p++) begin
      if (p == 6) write_shard_count(16'($urandom_range(65535, 2)));
      else write_shard_count(phase_counts[p]);
      case (p % 4)
        0: begin
          sender_gap_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          sender_gap_pct = 82;
          recv_stall_pct = 0;
        end
        2: begin
          sender_gap_pct = 0;
          recv_stall_pct = 82;
        end
        default: begin
          sender_gap_pct = 8;
          recv_stall_pct = 8;
        end
      endcase
      // back up the output while requests keep coming
      if (p == 0) hold_off_req++;
      for (int k = 0; k < PhaseItems; k++) begin
        if (p == 1 && k == PhaseItems / 2) drain_results();
        random_request();
      end
    end

    drain_results();
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d exact, %0d distributed, %0d clear and %0d other requests",
             n_exact, n_distrib, n_clear, n_other);
    $display("over %0d shard count settings; %0d result words checked, %0d mismatches",
             n_cfg, results_checked, error_count);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("** placement_resolver_round_robin_unit: PASSED **");
    end else begin
      $display("** placement_resolver_round_robin_unit: FAILED **");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/prr_pkg.sv
rtl/core/prr_mod_unit.sv
rtl/core/prr_stats.sv
rtl/core/placement_resolver_round_robin_unit.sv
rtl/core/prr_checker.sv
tb/sv/testbench.sv
